@@ hw/rtl/yab_pkg.sv @@
// Shared types, constants and helpers for the YUYV to ARGB white balance converter.
package yab_pkg;

  localparam int LUMA_W = 8;
  localparam int GAIN_W = 10;
  localparam int SUM_W  = 19;
  localparam int DIV_W  = SUM_W - 8;
  localparam int PROD_W = 22;
  localparam int SCL_W  = PROD_W - 8;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;
  localparam logic [7:0]        ALPHA      = 8'hFF;

  localparam logic [1:0] REG_RED_GAIN  = 2'd0;
  localparam logic [1:0] REG_BLUE_GAIN = 2'd1;

  localparam logic signed [SUM_W-1:0] COEF_Y   = 19'sd298;
  localparam logic signed [SUM_W-1:0] COEF_RV  = 19'sd409;
  localparam logic signed [SUM_W-1:0] COEF_GU  = 19'sd100;
  localparam logic signed [SUM_W-1:0] COEF_GV  = 19'sd208;
  localparam logic signed [SUM_W-1:0] COEF_BU  = 19'sd516;
  localparam logic signed [SUM_W-1:0] ROUND    = 19'sd128;
  localparam logic signed [8:0]       LUMA_OFS = 9'sd16;

  typedef struct packed {
    logic signed [PROD_W-1:0] red_prod;
    logic [7:0]               green;
    logic signed [PROD_W-1:0] blue_prod;
  } lane_out_t;

  function automatic logic [7:0] clamp_byte(input logic signed [SCL_W-1:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 14'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/yab_lane.sv @@
// One conversion lane: YUV to RGB for a single pixel, with red and blue gains.
module yab_lane (
  input  logic                         clk,
  input  logic [yab_pkg::LUMA_W-1:0]   luma,
  input  logic [yab_pkg::LUMA_W-1:0]   chroma_blue,
  input  logic [yab_pkg::LUMA_W-1:0]   chroma_red,
  input  logic [yab_pkg::GAIN_W-1:0]   red_gain,
  input  logic [yab_pkg::GAIN_W-1:0]   blue_gain,
  output yab_pkg::lane_out_t           lane_out
);

  logic signed [8:0]                  y_ofs;
  logic signed [8:0]                  cb;
  logic signed [8:0]                  cr;
  logic signed [yab_pkg::SUM_W-1:0]   y_ext;
  logic signed [yab_pkg::SUM_W-1:0]   cb_ext;
  logic signed [yab_pkg::SUM_W-1:0]   cr_ext;
  logic signed [yab_pkg::SUM_W-1:0]   red_sum_next;
  logic signed [yab_pkg::SUM_W-1:0]   green_sum_next;
  logic signed [yab_pkg::SUM_W-1:0]   blue_sum_next;
  logic signed [yab_pkg::SUM_W-1:0]   red_sum;
  logic signed [yab_pkg::SUM_W-1:0]   green_sum;
  logic signed [yab_pkg::SUM_W-1:0]   blue_sum;
  logic signed [yab_pkg::DIV_W-1:0]   red_div;
  logic signed [yab_pkg::DIV_W-1:0]   green_div;
  logic signed [yab_pkg::DIV_W-1:0]   blue_div;
  logic signed [yab_pkg::GAIN_W:0]    red_gain_s;
  logic signed [yab_pkg::GAIN_W:0]    blue_gain_s;
  logic signed [yab_pkg::PROD_W-1:0]  red_prod_next;
  logic signed [yab_pkg::PROD_W-1:0]  blue_prod_next;
  logic [7:0]                         green_next;
  logic signed [yab_pkg::PROD_W-1:0]  red_prod;
  logic signed [yab_pkg::PROD_W-1:0]  blue_prod;
  logic [7:0]                         green;

  always_comb begin
    y_ofs  = $signed({1'b0, luma}) - yab_pkg::LUMA_OFS;
    cb     = $signed({{1{~chroma_blue[7]}}, ~chroma_blue[7], chroma_blue[6:0]});
    cr     = $signed({{1{~chroma_red[7]}}, ~chroma_red[7], chroma_red[6:0]});
    y_ext  = yab_pkg::SUM_W'(y_ofs);
    cb_ext = yab_pkg::SUM_W'(cb);
    cr_ext = yab_pkg::SUM_W'(cr);
    red_sum_next   = y_ext * yab_pkg::COEF_Y + cr_ext * yab_pkg::COEF_RV + yab_pkg::ROUND;
    green_sum_next = y_ext * yab_pkg::COEF_Y - cb_ext * yab_pkg::COEF_GU
                     - cr_ext * yab_pkg::COEF_GV + yab_pkg::ROUND;
    blue_sum_next  = y_ext * yab_pkg::COEF_Y + cb_ext * yab_pkg::COEF_BU + yab_pkg::ROUND;
  end

  always_ff @(posedge clk) begin
    red_sum   <= red_sum_next;
    green_sum <= green_sum_next;
    blue_sum  <= blue_sum_next;
  end

  always_comb begin
    red_div        = red_sum[yab_pkg::SUM_W-1:8];
    green_div      = green_sum[yab_pkg::SUM_W-1:8];
    blue_div       = blue_sum[yab_pkg::SUM_W-1:8];
    red_gain_s     = $signed({1'b0, red_gain});
    blue_gain_s    = $signed({1'b0, blue_gain});
    red_prod_next  = yab_pkg::PROD_W'(red_div) * yab_pkg::PROD_W'(red_gain_s);
    blue_prod_next = yab_pkg::PROD_W'(blue_div) * yab_pkg::PROD_W'(blue_gain_s);
    green_next     = yab_pkg::clamp_byte(yab_pkg::SCL_W'(green_div));
  end

  always_ff @(posedge clk) begin
    red_prod  <= red_prod_next;
    blue_prod <= blue_prod_next;
    green     <= green_next;
  end

  assign lane_out.red_prod  = red_prod;
  assign lane_out.green     = green;
  assign lane_out.blue_prod = blue_prod;

endmodule

@@ hw/rtl/yuyv_to_argb_white_balance.sv @@
// Top level: YUYV macropixel to two ARGB8888 pixels with red/blue white balance.
// Takes one macropixel every clock: busy is always low, so start is accepted on
// any cycle. Each macropixel runs through two parallel conversion lanes (one per
// luma) and a merge stage; its two pixels and frame_end_out appear on the result
// ports three cycles after acceptance, marked by done for exactly one cycle, and
// must be captured then. The latency is set by the lane pipeline: coefficient
// sums, then gain multiply, then clamp and pack. Gain writes are always ready
// and apply to macropixels accepted after the write.
module yuyv_to_argb_white_balance (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  luma_first,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  luma_second,
  input  logic [7:0]  chroma_red,
  input  logic        frame_end_in,
  output logic        done,
  output logic [31:0] pixel_first,
  output logic [31:0] pixel_second,
  output logic        frame_end_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic [yab_pkg::GAIN_W-1:0] red_gain;
  logic [yab_pkg::GAIN_W-1:0] blue_gain;
  logic                       accept;
  logic                       valid_s1;
  logic                       valid_s2;
  logic                       fend_s1;
  logic                       fend_s2;
  yab_pkg::lane_out_t         lane_first;
  yab_pkg::lane_out_t         lane_second;
  logic [31:0]                pixel_first_next;
  logic [31:0]                pixel_second_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_gain  <= yab_pkg::GAIN_RESET;
      blue_gain <= yab_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        yab_pkg::REG_RED_GAIN:  red_gain  <= cfg_data;
        yab_pkg::REG_BLUE_GAIN: blue_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  yab_lane u_lane_first (
    .clk         (clk),
    .luma        (luma_first),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .red_gain    (red_gain),
    .blue_gain   (blue_gain),
    .lane_out    (lane_first)
  );

  yab_lane u_lane_second (
    .clk         (clk),
    .luma        (luma_second),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .red_gain    (red_gain),
    .blue_gain   (blue_gain),
    .lane_out    (lane_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_s2 <= 1'b0;
      done     <= 1'b0;
    end else begin
      valid_s1 <= accept;
      valid_s2 <= valid_s1;
      done     <= valid_s2;
    end
  end

  always_comb begin
    pixel_first_next = {yab_pkg::ALPHA,
      yab_pkg::clamp_byte(lane_first.red_prod[yab_pkg::PROD_W-1:8]),
      lane_first.green,
      yab_pkg::clamp_byte(lane_first.blue_prod[yab_pkg::PROD_W-1:8])};
    pixel_second_next = {yab_pkg::ALPHA,
      yab_pkg::clamp_byte(lane_second.red_prod[yab_pkg::PROD_W-1:8]),
      lane_second.green,
      yab_pkg::clamp_byte(lane_second.blue_prod[yab_pkg::PROD_W-1:8])};
  end

  always_ff @(posedge clk) begin
    fend_s1       <= frame_end_in;
    fend_s2       <= fend_s1;
    frame_end_out <= fend_s2;
    pixel_first   <= pixel_first_next;
    pixel_second  <= pixel_second_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("result word missing three cycles after accept");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> (pixel_first[31:24] == yab_pkg::ALPHA) && (pixel_second[31:24] == yab_pkg::ALPHA))
    else $error("alpha byte not opaque");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    done |-> frame_end_out == $past(frame_end_in, 3))
    else $error("frame end marker out of step with its word");

  a_red_gain: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == yab_pkg::REG_RED_GAIN)
    |=> red_gain == $past(cfg_data))
    else $error("red gain write lost");

endmodule
